/* design/tdc_pkg.sv */
// Shared widths, codes and control bundles for the tilt direction classifier.
`timescale 1ns / 1ps
`default_nettype none
package tdc_pkg;

  localparam int WINDOW     = 8;
  localparam int ELAPSED_W  = 16;
  localparam int ACCEL_W    = 16;
  localparam int PERIOD_W   = 16;
  localparam int THRESH_W   = 15;
  localparam int DIR_W      = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam int CNT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W = ACCEL_W + $clog2(WINDOW);
  localparam int LIM_W = THRESH_W + $clog2(WINDOW + 1);
  localparam int CMP_W = (SUM_W > LIM_W) ? SUM_W : LIM_W;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(50);
  localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(1253);
  localparam logic [CNT_W-1:0]    CNT_LAST     = CNT_W'(WINDOW - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_PERIOD  = 1'b0,
    REG_TILT_THRESHOLD = 1'b1
  } cfg_reg_t;

  typedef enum logic [DIR_W-1:0] {
    DIR_STAY  = 3'd0,
    DIR_RIGHT = 3'd1,
    DIR_LEFT  = 3'd2,
    DIR_DOWN  = 3'd3,
    DIR_UP    = 3'd4
  } dir_t;

  typedef struct packed {
    logic take;
    logic close;
  } lane_ctl_t;

  typedef struct packed {
    logic adv;
    logic close;
  } merge_ctl_t;

endpackage
`default_nettype wire

/* design/tdc_lane.sv */
// One axis lane: running window sum and the registered closed-window sum.
`timescale 1ns / 1ps
`default_nettype none
module tdc_lane (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire tdc_pkg::lane_ctl_t                ctl,
  input  wire logic signed [tdc_pkg::ACCEL_W-1:0] sample,
  output logic signed [tdc_pkg::SUM_W-1:0]        win_sum
);
  import tdc_pkg::*;

  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] sum_next;

  assign sum_next = sum + SUM_W'(sample);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (ctl.take) begin
      sum <= ctl.close ? '0 : sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take && ctl.close) begin
      win_sum <= sum_next;
    end
  end

endmodule
`default_nettype wire

/* design/tdc_merge.sv */
// Merge stage: compares the lane sums, holds the current direction, drives the result beat.
`timescale 1ns / 1ps
`default_nettype none
module tdc_merge (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire tdc_pkg::merge_ctl_t                ctl,
  input  wire logic signed [tdc_pkg::SUM_W-1:0]   x_win,
  input  wire logic signed [tdc_pkg::SUM_W-1:0]   y_win,
  input  wire logic [tdc_pkg::THRESH_W-1:0]       threshold,
  output logic [tdc_pkg::DIR_W-1:0]               direction,
  output logic                                    decision_new
);
  import tdc_pkg::*;

  dir_t             current_direction;
  dir_t             decided;
  logic [LIM_W-1:0] lim;
  logic [SUM_W-1:0] x_mag;
  logic [SUM_W-1:0] y_mag;
  logic             x_over;
  logic             y_over;

  always_comb begin
    lim    = LIM_W'(threshold) * LIM_W'(WINDOW);
    x_mag  = x_win[SUM_W-1] ? SUM_W'(-x_win) : SUM_W'(x_win);
    y_mag  = y_win[SUM_W-1] ? SUM_W'(-y_win) : SUM_W'(y_win);
    x_over = CMP_W'(x_mag) > CMP_W'(lim);
    y_over = CMP_W'(y_mag) > CMP_W'(lim);
    if (x_mag > y_mag) begin
      if (!x_over) begin
        decided = DIR_STAY;
      end else begin
        decided = x_win[SUM_W-1] ? DIR_RIGHT : DIR_LEFT;
      end
    end else begin
      if (!y_over) begin
        decided = DIR_STAY;
      end else begin
        decided = y_win[SUM_W-1] ? DIR_UP : DIR_DOWN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_direction <= DIR_STAY;
    end else if (ctl.adv && ctl.close) begin
      current_direction <= decided;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      direction    <= ctl.close ? decided : current_direction;
      decision_new <= ctl.close;
    end
  end

endmodule
`default_nettype wire

/* design/tilt_direction_classifier_unit.sv */
// Top level of the tilt direction classifier: sample timing, lanes, merge and handshake.
`timescale 1ns / 1ps
`default_nettype none
// Takes one step per clock unless in_stall is high and gives one result beat per step. The
// X and Y lanes update their window sums in the accept cycle of a sampled step (lane stage);
// the merge stage decides on the closed sums as the beat enters its output register. in_stall
// rises only while both the lane stage and the output register hold beats and out_stall
// is high. Register writes through cfg_write/cfg_index/cfg_data take effect at once.
module tilt_direction_classifier_unit (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_write,
  input  wire logic [tdc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [tdc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [tdc_pkg::ELAPSED_W-1:0]      elapsed_ms,
  input  wire logic signed [tdc_pkg::ACCEL_W-1:0] accel_x,
  input  wire logic signed [tdc_pkg::ACCEL_W-1:0] accel_y,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [tdc_pkg::DIR_W-1:0]               direction,
  output logic                                    decision_new
);
  import tdc_pkg::*;

  logic [PERIOD_W-1:0]  sample_period_ms;
  logic [THRESH_W-1:0]  tilt_threshold;
  logic [ELAPSED_W-1:0] time_accum;
  logic [ELAPSED_W:0]   time_sum;
  logic [ELAPSED_W-1:0] time_sat;
  logic [CNT_W-1:0]     sample_count;
  logic                 s1_valid;
  logic                 s1_close;
  logic                 out_free;
  logic                 accept;
  logic                 take;
  logic                 close;
  lane_ctl_t            lane_ctl;
  merge_ctl_t           merge_ctl;
  logic signed [SUM_W-1:0] x_win;
  logic signed [SUM_W-1:0] y_win;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_period_ms <= PERIOD_RESET;
      tilt_threshold   <= THRESH_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_SAMPLE_PERIOD:  sample_period_ms <= cfg_data[PERIOD_W-1:0];
        REG_TILT_THRESHOLD: tilt_threshold   <= cfg_data[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    out_free = !out_valid || !out_stall;
    in_stall = s1_valid && !out_free;
    accept   = in_valid && !in_stall;
    time_sum = {1'b0, time_accum} + {1'b0, elapsed_ms};
    time_sat = time_sum[ELAPSED_W] ? '1 : time_sum[ELAPSED_W-1:0];
    take     = accept && (time_sat >= sample_period_ms);
    close    = take && (sample_count == CNT_LAST);
    lane_ctl.take   = take;
    lane_ctl.close  = close;
    merge_ctl.adv   = s1_valid && out_free;
    merge_ctl.close = s1_close;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_accum   <= '0;
      sample_count <= '0;
    end else if (accept) begin
      time_accum <= take ? '0 : time_sat;
      if (take) begin
        sample_count <= close ? '0 : sample_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept || out_free) begin
        s1_valid <= accept;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_close <= close;
    end
  end

  tdc_lane u_lane_x (
    .clk     (clk),
    .rst     (rst),
    .ctl     (lane_ctl),
    .sample  (accel_x),
    .win_sum (x_win)
  );

  tdc_lane u_lane_y (
    .clk     (clk),
    .rst     (rst),
    .ctl     (lane_ctl),
    .sample  (accel_y),
    .win_sum (y_win)
  );

  tdc_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .ctl          (merge_ctl),
    .x_win        (x_win),
    .y_win        (y_win),
    .threshold    (tilt_threshold),
    .direction    (direction),
    .decision_new (decision_new)
  );

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled with room downstream");

  a_time_cleared_on_sample: assert property (@(posedge clk) disable iff (rst)
    take |=> (time_accum == '0))
    else $error("time not cleared after sample");

  a_count_holds_when_idle: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(sample_count))
    else $error("sample count moved without a beat");

  a_count_in_window: assert property (@(posedge clk) disable iff (rst)
    sample_count <= CNT_LAST)
    else $error("sample count beyond window");

endmodule
`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench for the tilt direction classifier unit.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import tdc_pkg::*;

  localparam int IDLE_LIMIT = 3000;
  localparam int MAG_W      = CMP_W + 2;

  typedef struct {
    logic [ELAPSED_W-1:0]      elapsed;
    logic signed [ACCEL_W-1:0] ax;
    logic signed [ACCEL_W-1:0] ay;
  } step_t;

  typedef struct {
    dir_t dir;
    logic fresh;
  } verdict_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = REG_SAMPLE_PERIOD;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [ELAPSED_W-1:0]      elapsed_ms = '0;
  logic signed [ACCEL_W-1:0] accel_x = '0;
  logic signed [ACCEL_W-1:0] accel_y = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [DIR_W-1:0]          direction;
  logic                      decision_new;

  step_t    step_q[$];
  verdict_t verdict_q[$];

  logic [PERIOD_W-1:0]     period_reg = PERIOD_RESET;
  logic [THRESH_W-1:0]     thresh_reg = THRESH_RESET;
  logic [ELAPSED_W-1:0]    ms_acc = '0;
  int                      sample_cnt = 0;
  logic signed [SUM_W-1:0] x_acc = '0;
  logic signed [SUM_W-1:0] y_acc = '0;
  dir_t                    cur_dir = DIR_STAY;

  logic steady = 1'b0;
  int   err_cnt = 0;
  int   steps_seen = 0;
  int   windows_seen = 0;
  int   tilts_seen = 0;
  int   idle_cycles = 0;

  tilt_direction_classifier_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .elapsed_ms   (elapsed_ms),
    .accel_x      (accel_x),
    .accel_y      (accel_y),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .direction    (direction),
    .decision_new (decision_new)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic dir_t tilt_of(logic signed [SUM_W-1:0] xs, logic signed [SUM_W-1:0] ys);
    logic signed [MAG_W-1:0] xw;
    logic signed [MAG_W-1:0] yw;
    logic signed [MAG_W-1:0] xm;
    logic signed [MAG_W-1:0] ym;
    logic signed [MAG_W-1:0] lim;
    xw  = MAG_W'(xs);
    yw  = MAG_W'(ys);
    xm  = (xw < 0) ? -xw : xw;
    ym  = (yw < 0) ? -yw : yw;
    lim = MAG_W'(thresh_reg) * MAG_W'(WINDOW);
    if (xm > ym) begin
      if (xw < -lim) return DIR_RIGHT;
      if (xw > lim) return DIR_LEFT;
      return DIR_STAY;
    end
    if (yw > lim) return DIR_DOWN;
    if (yw < -lim) return DIR_UP;
    return DIR_STAY;
  endfunction

  task automatic advance_tilt(step_t s);
    logic [ELAPSED_W:0] t;
    verdict_t v;
    t = {1'b0, ms_acc} + {1'b0, s.elapsed};
    if (t[ELAPSED_W]) t = {1'b0, {ELAPSED_W{1'b1}}};
    ms_acc  = t[ELAPSED_W-1:0];
    v.fresh = 1'b0;
    if (ms_acc >= period_reg) begin
      x_acc = x_acc + SUM_W'(s.ax);
      y_acc = y_acc + SUM_W'(s.ay);
      sample_cnt++;
      if (sample_cnt >= WINDOW) begin
        cur_dir    = tilt_of(x_acc, y_acc);
        sample_cnt = 0;
        x_acc      = '0;
        y_acc      = '0;
        v.fresh    = 1'b1;
      end
      ms_acc = '0;
    end
    v.dir = cur_dir;
    verdict_q.push_back(v);
  endtask

  // driver: advance on accept, idle at random
  always @(posedge clk) begin : drive_steps
    step_t s;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (step_q.size() != 0 && (steady || $urandom_range(0, 99) >= 23)) begin
        s = step_q.pop_front();
        in_valid   <= 1'b1;
        elapsed_ms <= s.elapsed;
        accel_x    <= s.ax;
        accel_y    <= s.ay;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: predict on input beat, check on output beat
  always @(posedge clk) begin : watch_results
    step_t s;
    verdict_t v;
    out_stall <= !rst && !steady && ($urandom_range(0, 99) < 23);
    if (!rst) begin
      if (in_valid && !in_stall) begin
        s.elapsed = elapsed_ms;
        s.ax      = accel_x;
        s.ay      = accel_y;
        advance_tilt(s);
        steps_seen++;
      end
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected beat: direction %0d decision_new %0b",
                   $time, direction, decision_new);
          err_cnt++;
        end else begin
          v = verdict_q.pop_front();
          if (direction !== v.dir) begin
            $display("%0t: direction expected %0d actual %0d", $time, v.dir, direction);
            err_cnt++;
          end
          if (decision_new !== v.fresh) begin
            $display("%0t: decision_new expected %0b actual %0b", $time, v.fresh,
                     decision_new);
            err_cnt++;
          end
          if (v.fresh) begin
            windows_seen++;
            if (v.dir != DIR_STAY) tilts_seen++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
      $display("tilt_direction_classifier_unit test failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (step_q.size() != 0 || verdict_q.size() != 0 || in_valid) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_SAMPLE_PERIOD) period_reg = data[PERIOD_W-1:0];
    else thresh_reg = data[THRESH_W-1:0];
  endtask

  task automatic push_step(int e, int x, int y);
    step_t s;
    s.elapsed = ELAPSED_W'(e);
    s.ax      = ACCEL_W'(x);
    s.ay      = ACCEL_W'(y);
    step_q.push_back(s);
  endtask

  function automatic int clip16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // windows of biased samples around the threshold, with some raw noise
  task automatic queue_random(int n);
    int span;
    int amp;
    int bx;
    int by;
    int p;
    int e;
    int k;
    step_t s;
    bx  = 0;
    by  = 0;
    amp = 0;
    p   = int'(period_reg);
    for (int i = 0; i < n; i++) begin
      if (i % WINDOW == 0) begin
        span = 2 * int'(thresh_reg) + 256;
        bx   = int'($urandom_range(0, 2 * span)) - span;
        by   = int'($urandom_range(0, 2 * span)) - span;
        amp  = int'(thresh_reg) / 4 + 32;
        k    = $urandom_range(0, 5);
        if (k == 0) begin
          by  = ($urandom_range(0, 1) != 0) ? bx : -bx;
          amp = 0;
        end else if (k == 1) begin
          bx = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
        end
      end
      if ($urandom_range(0, 99) < 10) begin
        s.elapsed = ELAPSED_W'($urandom);
        s.ax      = ACCEL_W'($urandom);
        s.ay      = ACCEL_W'($urandom);
        step_q.push_back(s);
      end else begin
        k = $urandom_range(0, 9);
        if (k <= 5) e = (p == 0) ? int'($urandom_range(0, 3)) : p;
        else if (k <= 7) e = (p == 0) ? 0 : int'($urandom_range(0, p - 1));
        else if (k == 8) e = 0;
        else e = int'($urandom_range(p, 65535));
        push_step(e, clip16(bx + int'($urandom_range(0, 2 * amp)) - amp),
                  clip16(by + int'($urandom_range(0, 2 * amp)) - amp));
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: partial time, then strong left, tie to down, up
    push_step(0, 1, -1);
    push_step(49, 32767, 0);
    push_step(1, 32767, 0);
    for (int i = 0; i < 7; i++) push_step(50, 32767, 0);
    for (int i = 0; i < 8; i++) push_step(50, -32767, 32767);
    for (int i = 0; i < 8; i++) push_step(65535, 0, -32768);
    queue_random(150);

    write_reg(REG_SAMPLE_PERIOD, 16'd1);
    write_reg(REG_TILT_THRESHOLD, 16'd0);
    queue_random(100);
    wait_drained();
    queue_random(100);

    write_reg(REG_SAMPLE_PERIOD, 16'h0000);
    write_reg(REG_TILT_THRESHOLD, 16'hFFFF);
    queue_random(200);

    // saturate the time accumulator
    write_reg(REG_SAMPLE_PERIOD, 16'hFFFF);
    write_reg(REG_TILT_THRESHOLD, 16'd1253);
    push_step(40000, 32767, 32767);
    push_step(40000, -32768, -32768);
    push_step(65535, 12345, -12345);
    queue_random(150);

    write_reg(REG_SAMPLE_PERIOD, 16'd3);
    write_reg(REG_TILT_THRESHOLD, 16'd600);
    wait_drained();
    steady <= 1'b1;
    queue_random(200);
    wait_drained();
    steady <= 1'b0;

    write_reg(REG_SAMPLE_PERIOD, 16'($urandom_range(1, 200)));
    write_reg(REG_TILT_THRESHOLD, 16'($urandom_range(0, 8000)));
    queue_random(200);

    write_reg(REG_SAMPLE_PERIOD, 16'(PERIOD_RESET));
    write_reg(REG_TILT_THRESHOLD, 16'(THRESH_RESET));
    queue_random(150);

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Covered %0d steps over seven register settings: %0d windows closed, %0d tilts.",
             steps_seen, windows_seen, tilts_seen);
    if (err_cnt == 0) begin
      $display("tilt_direction_classifier_unit test passed");
    end else begin
      $display("tilt_direction_classifier_unit test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* files.f */
design/tdc_pkg.sv
design/tdc_lane.sv
design/tdc_merge.sv
design/tilt_direction_classifier_unit.sv
sim/testbench.sv
